>>> design/hirl_pkg.sv
// Shared types and constants for the hex ID range list parser.
// No dependencies; used by hirl_step, the top level and the checker.
`default_nettype none

package hirl_pkg;

    localparam int ID_BITS = 16;

    // Character codes
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;

    // Register indexes
    localparam logic REG_SEMICOLON_SEPARATOR = 1'b0;

    typedef enum logic [1:0] {
        PH_BETWEEN     = 2'd0,
        PH_FIRST       = 2'd1,
        PH_AFTER_FIRST = 2'd2,
        PH_SECOND      = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RANGE  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef struct packed {
        phase_t              phase;
        logic [2:0]          digit_pos;
        logic [ID_BITS-1:0]  acc;
        logic [ID_BITS-1:0]  start_id;
        logic                saw_token;
        logic                discarding;
    } parse_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_BITS-1:0]  first;
        logic [ID_BITS-1:0]  last;
        logic                eor;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_out_t;

endpackage

`default_nettype wire

>>> design/hirl_step.sv
// Combinational step of the parser: one character against the running state.
// Depends on hirl_pkg.
`default_nettype none

module hirl_step (
    input  wire hirl_pkg::parse_state_t cur,
    input  wire logic [7:0]             char_code,
    input  wire logic                   end_of_list,
    input  wire logic                   semi_en,
    output hirl_pkg::parse_state_t      nxt,
    output hirl_pkg::step_out_t         results
);

    // digit_pos codes: digits taken, colon after two, colon plus one digit
    localparam logic [2:0] DP_ZERO      = 3'd0;
    localparam logic [2:0] DP_TWO       = 3'd2;
    localparam logic [2:0] DP_THREE     = 3'd3;
    localparam logic [2:0] DP_COLON     = 3'd4;
    localparam logic [2:0] DP_COLON_ONE = 3'd5;

    localparam hirl_pkg::parse_state_t RESTART = '{
        phase:      hirl_pkg::PH_BETWEEN,
        digit_pos:  DP_ZERO,
        acc:        '0,
        start_id:   '0,
        saw_token:  1'b0,
        discarding: 1'b0
    };

    logic                         is_sep;
    logic                         is_hyphen;
    logic                         hex_ok;
    logic [3:0]                   hex_nib;
    logic                         fresh;
    logic [2:0]                   p_in;
    logic [hirl_pkg::ID_BITS-1:0] acc_in;
    logic                         colon_take;
    logic                         feed_bad;
    logic                         feed_done;
    logic [hirl_pkg::ID_BITS-1:0] acc_fed;
    logic [2:0]                   p_fed;

    logic                         bad;
    logic                         accept_v;
    logic                         rng_v;
    logic [hirl_pkg::ID_BITS-1:0] rng_first;
    logic [hirl_pkg::ID_BITS-1:0] rng_last;

    // character classes
    always_comb
    begin
        is_sep = (char_code == hirl_pkg::CHAR_SPACE)
              || (char_code >= hirl_pkg::CHAR_TAB && char_code <= hirl_pkg::CHAR_CR)
              || (semi_en && char_code == hirl_pkg::CHAR_SEMI);
        is_hyphen = (char_code == hirl_pkg::CHAR_HYPHEN);
        hex_ok  = 1'b0;
        hex_nib = 4'd0;
        if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            hex_ok  = 1'b1;
            hex_nib = char_code[3:0];
        end
        else if ((char_code >= 8'h61 && char_code <= 8'h66)
              || (char_code >= 8'h41 && char_code <= 8'h46))
        begin
            hex_ok  = 1'b1;
            hex_nib = char_code[3:0] + 4'd9;
        end
    end

    // ID digit reader; a fresh token starts from an empty accumulator
    always_comb
    begin
        fresh = (cur.phase == hirl_pkg::PH_BETWEEN)
             || (cur.phase == hirl_pkg::PH_AFTER_FIRST && !is_hyphen);
        p_in   = fresh ? DP_ZERO : cur.digit_pos;
        acc_in = fresh ? '0 : cur.acc;
        colon_take = (p_in == DP_TWO) && (char_code == hirl_pkg::CHAR_COLON);
        feed_bad   = !colon_take && (!hex_ok || p_in > DP_COLON_ONE);
        feed_done  = !colon_take && !feed_bad
                  && (p_in == DP_THREE || p_in == DP_COLON_ONE);
        acc_fed = colon_take ? acc_in : {acc_in[hirl_pkg::ID_BITS-5:0], hex_nib};
        p_fed   = colon_take ? DP_COLON : (feed_done ? DP_ZERO : p_in + 3'd1);
    end

    // next state and emission flags
    always_comb
    begin
        nxt       = cur;
        bad       = 1'b0;
        accept_v  = 1'b0;
        rng_v     = 1'b0;
        rng_first = '0;
        rng_last  = '0;
        if (cur.discarding)
        begin
            if (end_of_list)
                nxt = RESTART;
        end
        else
        begin
            unique case (cur.phase)
                hirl_pkg::PH_AFTER_FIRST:
                begin
                    if (is_hyphen)
                    begin
                        nxt.phase     = hirl_pkg::PH_SECOND;
                        nxt.digit_pos = DP_ZERO;
                        nxt.acc       = '0;
                    end
                    else
                    begin
                        rng_v         = 1'b1;
                        rng_first     = cur.start_id;
                        rng_last      = cur.start_id;
                        nxt.saw_token = 1'b1;
                        nxt.phase     = hirl_pkg::PH_BETWEEN;
                        if (!is_sep)
                        begin
                            nxt.phase     = hirl_pkg::PH_FIRST;
                            nxt.acc       = acc_fed;
                            nxt.digit_pos = p_fed;
                            bad           = feed_bad;
                        end
                    end
                end
                hirl_pkg::PH_FIRST:
                begin
                    nxt.acc       = acc_fed;
                    nxt.digit_pos = p_fed;
                    if (feed_bad)
                        bad = 1'b1;
                    else if (feed_done)
                    begin
                        nxt.start_id = acc_fed;
                        nxt.phase    = hirl_pkg::PH_AFTER_FIRST;
                    end
                end
                hirl_pkg::PH_SECOND:
                begin
                    nxt.acc       = acc_fed;
                    nxt.digit_pos = p_fed;
                    if (feed_bad)
                        bad = 1'b1;
                    else if (feed_done)
                    begin
                        if (acc_fed < cur.start_id)
                            bad = 1'b1;
                        else
                        begin
                            rng_v         = 1'b1;
                            rng_first     = cur.start_id;
                            rng_last      = acc_fed;
                            nxt.saw_token = 1'b1;
                            nxt.phase     = hirl_pkg::PH_BETWEEN;
                        end
                    end
                end
                hirl_pkg::PH_BETWEEN:
                begin
                    if (!is_sep)
                    begin
                        nxt.phase     = hirl_pkg::PH_FIRST;
                        nxt.acc       = acc_fed;
                        nxt.digit_pos = p_fed;
                        bad           = feed_bad;
                    end
                end
            endcase

            // end of list closes any pending singleton, then accept or reject
            if (!bad && end_of_list)
            begin
                if (nxt.phase == hirl_pkg::PH_AFTER_FIRST)
                begin
                    rng_v         = 1'b1;
                    rng_first     = nxt.start_id;
                    rng_last      = nxt.start_id;
                    nxt.saw_token = 1'b1;
                    nxt.phase     = hirl_pkg::PH_BETWEEN;
                end
                if (nxt.phase == hirl_pkg::PH_BETWEEN && nxt.saw_token)
                begin
                    accept_v = 1'b1;
                    nxt      = RESTART;
                end
                else
                    bad = 1'b1;
            end

            if (bad)
            begin
                nxt            = RESTART;
                nxt.discarding = !end_of_list;
            end
        end
    end

    // result words: the range (if any) goes ahead of the closing word
    always_comb
    begin
        hirl_pkg::result_t range_res;
        hirl_pkg::result_t term_res;
        logic              term_v;
        term_v          = accept_v || bad;
        range_res.kind  = hirl_pkg::KIND_RANGE;
        range_res.first = rng_first;
        range_res.last  = rng_last;
        range_res.eor   = !term_v;
        term_res.kind   = bad ? hirl_pkg::KIND_REJECT : hirl_pkg::KIND_ACCEPT;
        term_res.first  = '0;
        term_res.last   = '0;
        term_res.eor    = 1'b1;
        results.count   = {1'b0, rng_v} + {1'b0, term_v};
        results.res0    = rng_v ? range_res : term_res;
        results.res1    = term_res;
    end

endmodule

`default_nettype wire

>>> design/hex_id_range_list_parser_core.sv
// Top level of the hex ID range list parser: stream ports, APB register, result queue.
// Depends on hirl_pkg and hirl_step.
//
// Takes one character word per clock on the s_ side while s_tready is high
// and parses a list of 16-bit hex IDs ("01af" or "01:AF"), alone or as ranges
// "first-last", separated by whitespace (and ';' when semicolon_separator is set).
// Every character is handled in the cycle it is taken: the running state
// updates at that edge and the character's results (none, one or two) go
// into a four-word result queue. m_ words leave that queue one per clock
// while m_tready is high, so input runs at one character per cycle only
// while at most one result word per character is produced. s_tready drops
// while fewer than two queue slots are free, so the queue depth and the
// one-word-per-cycle output port set the sustained rate. A list ends in
// exactly one accept or reject word; after a reject the characters up to
// the end-flagged one produce nothing. Results: m_tuser = kind (0 range,
// 1 accept, 2 reject), m_tlast marks the last word caused by one character.
// The register must be written only while the block is idle; the block
// itself does not enforce it.
`default_nettype none

module hex_id_range_list_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // character stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_list
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] range_first, [31:16] range_last
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,   // end_of_run
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    hirl_pkg::parse_state_t state_reg;
    hirl_pkg::parse_state_t state_next;
    hirl_pkg::step_out_t    step_res;
    logic                   semi_en_reg;

    // result queue, four words
    hirl_pkg::result_t      q_reg [4];
    logic [1:0]             wr_ptr_reg;
    logic [1:0]             rd_ptr_reg;
    logic [2:0]             count_reg;
    logic [2:0]             count_next;

    logic                   in_fire;
    logic                   out_fire;
    logic [1:0]             push_n;
    logic                   cfg_wr;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            semi_en_reg <= 1'b0;
        else if (cfg_wr && paddr[2] == hirl_pkg::REG_SEMICOLON_SEPARATOR)
            semi_en_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hirl_pkg::REG_SEMICOLON_SEPARATOR)
            prdata[0] = semi_en_reg;
    end

    // ---------------- parser ----------------
    hirl_step u_step (
        .cur         (state_reg),
        .char_code   (s_tdata),
        .end_of_list (s_tlast),
        .semi_en     (semi_en_reg),
        .nxt         (state_next),
        .results     (step_res)
    );

    // room for the worst case of two words per character
    assign s_tready = (count_reg <= 3'd2);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign push_n   = in_fire ? step_res.count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= hirl_pkg::PH_BETWEEN;
            state_reg.digit_pos  <= '0;
            state_reg.acc        <= '0;
            state_reg.start_id   <= '0;
            state_reg.saw_token  <= 1'b0;
            state_reg.discarding <= 1'b0;
        end
        else if (in_fire)
            state_reg <= state_next;
    end

    // ---------------- result queue ----------------
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_ptr_reg] <= step_res.res0;
        if (push_n == 2'd2)
            q_reg[wr_ptr_reg + 2'd1] <= step_res.res1;
    end

    assign count_next = count_reg + {1'b0, push_n} - {2'b00, out_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, out_fire};
            count_reg  <= count_next;
        end
    end

    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {q_reg[rd_ptr_reg].last, q_reg[rd_ptr_reg].first};
    assign m_tuser  = q_reg[rd_ptr_reg].kind;
    assign m_tlast  = q_reg[rd_ptr_reg].eor;

endmodule

`default_nettype wire

>>> design/hirl_checker.sv
// Port-level assertions for the hex ID range list parser, bound to the top level.
// Depends on hirl_pkg and hex_id_range_list_parser_core.
`default_nettype none

module hirl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // no undefined kind code leaves the block
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined result kind");

    // accept and reject close the run and carry no IDs
    a_close_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != hirl_pkg::KIND_RANGE |-> m_tlast && m_tdata == 32'd0)
        else $error("closing word malformed");

    // ranges are never backwards
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == hirl_pkg::KIND_RANGE |-> m_tdata[15:0] <= m_tdata[31:16])
        else $error("backwards range emitted");

endmodule

bind hex_id_range_list_parser_core hirl_checker u_hirl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
